@@ design/hk_pkg.sv @@
package hk_pkg;

  localparam int unsigned CodeWidth   = 16;
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned VolWidth    = 5;
  localparam int unsigned BriWidth    = 4;
  localparam int unsigned KeyValWidth = 2;

  localparam logic [VolWidth-1:0] VolumeTop     = 5'd20;
  localparam logic [BriWidth-1:0] BrightnessTop = 4'd10;

  localparam logic [CfgWidth-1:0] RepeatDelayRst    = 16'd300;
  localparam logic [CfgWidth-1:0] RepeatIntervalRst = 16'd100;
  localparam logic [CfgWidth-1:0] SleepGapRst       = 16'd1000;
  localparam logic [VolWidth-1:0] VolumeStartRst    = 5'd0;
  localparam logic [BriWidth-1:0] BrightnessStartRst = 4'd0;

  typedef enum logic [1:0] {
    CMD_FRAME_BEGIN = 2'd0,
    CMD_KEY_EVENT   = 2'd1,
    CMD_FRAME_END   = 2'd2
  } cmd_e;

  typedef enum logic [KeyValWidth-1:0] {
    KEY_RELEASED = 2'd0,
    KEY_PRESSED  = 2'd1,
    KEY_REPEAT   = 2'd2,
    KEY_OTHER    = 2'd3
  } key_val_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MENU_KEY         = 3'd0,
    REG_UP_KEY           = 3'd1,
    REG_DOWN_KEY         = 3'd2,
    REG_REPEAT_DELAY     = 3'd3,
    REG_REPEAT_INTERVAL  = 3'd4,
    REG_SLEEP_GAP        = 3'd5,
    REG_VOLUME_START     = 3'd6,
    REG_BRIGHTNESS_START = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]             command;
    logic [TimeWidth-1:0]   time_ms;
    logic                   event_is_key;
    logic [CodeWidth-1:0]   key_code;
    logic [KeyValWidth-1:0] key_value;
  } item_t;

  typedef struct packed {
    logic [VolWidth-1:0] volume;
    logic [BriWidth-1:0] brightness;
    logic                level_changed;
  } result_t;

  typedef struct packed {
    logic [CodeWidth-1:0] menu_key_code;
    logic [CodeWidth-1:0] up_key_code;
    logic [CodeWidth-1:0] down_key_code;
    logic [CfgWidth-1:0]  repeat_delay_ms;
    logic [CfgWidth-1:0]  repeat_interval_ms;
    logic [CfgWidth-1:0]  sleep_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic                vol_load;
    logic [VolWidth-1:0] vol_value;
    logic                bri_load;
    logic [BriWidth-1:0] bri_value;
  } level_load_t;

  function automatic logic [VolWidth-1:0] step_volume(logic [VolWidth-1:0] lvl,
                                                      logic raise);
    logic [VolWidth-1:0] res;
    res = lvl;
    if (raise) begin
      if (lvl < VolumeTop) res = lvl + 5'd1;
    end else if (lvl != '0) begin
      res = lvl - 5'd1;
    end
    return res;
  endfunction

  function automatic logic [BriWidth-1:0] step_brightness(logic [BriWidth-1:0] lvl,
                                                          logic raise);
    logic [BriWidth-1:0] res;
    res = lvl;
    if (raise) begin
      if (lvl < BrightnessTop) res = lvl + 4'd1;
    end else if (lvl != '0) begin
      res = lvl - 4'd1;
    end
    return res;
  endfunction

endpackage

@@ design/hk_item_if.sv @@
interface hk_item_if;
  import hk_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             command;
  logic [TimeWidth-1:0]   time_ms;
  logic                   event_is_key;
  logic [CodeWidth-1:0]   key_code;
  logic [KeyValWidth-1:0] key_value;

  modport source (output valid, command, time_ms, event_is_key, key_code, key_value,
                  input ready);
  modport sink (input valid, command, time_ms, event_is_key, key_code, key_value,
                output ready);
endinterface

interface hk_result_if;
  import hk_pkg::*;

  logic                valid;
  logic                ready;
  logic [VolWidth-1:0] volume;
  logic [BriWidth-1:0] brightness;
  logic                level_changed;

  modport source (output valid, volume, brightness, level_changed, input ready);
  modport sink (input valid, volume, brightness, level_changed, output ready);
endinterface

@@ design/hk_cfg_regs.sv @@
module hk_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hk_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [hk_pkg::CfgWidth-1:0]         cfg_wdata_i,
  output hk_pkg::cfg_t                        cfg_o,
  output hk_pkg::level_load_t                 load_o
);
  import hk_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d  = cfg_q;
    load_o = '0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MENU_KEY:        cfg_d.menu_key_code      = cfg_wdata_i;
        REG_UP_KEY:          cfg_d.up_key_code        = cfg_wdata_i;
        REG_DOWN_KEY:        cfg_d.down_key_code      = cfg_wdata_i;
        REG_REPEAT_DELAY:    cfg_d.repeat_delay_ms    = cfg_wdata_i;
        REG_REPEAT_INTERVAL: cfg_d.repeat_interval_ms = cfg_wdata_i;
        REG_SLEEP_GAP:       cfg_d.sleep_gap_ms       = cfg_wdata_i;
        REG_VOLUME_START: begin
          load_o.vol_load  = 1'b1;
          load_o.vol_value = (cfg_wdata_i[VolWidth-1:0] > VolumeTop) ?
                             VolumeTop : cfg_wdata_i[VolWidth-1:0];
        end
        REG_BRIGHTNESS_START: begin
          load_o.bri_load  = 1'b1;
          load_o.bri_value = (cfg_wdata_i[BriWidth-1:0] > BrightnessTop) ?
                             BrightnessTop : cfg_wdata_i[BriWidth-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.menu_key_code      <= '0;
      cfg_q.up_key_code        <= '0;
      cfg_q.down_key_code      <= '0;
      cfg_q.repeat_delay_ms    <= RepeatDelayRst;
      cfg_q.repeat_interval_ms <= RepeatIntervalRst;
      cfg_q.sleep_gap_ms       <= SleepGapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/hk_level_core.sv @@
module hk_level_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  hk_pkg::item_t       item_i,
  input  hk_pkg::cfg_t        cfg_i,
  input  hk_pkg::level_load_t load_i,
  output hk_pkg::result_t     result_o
);
  import hk_pkg::*;

  logic [VolWidth-1:0]    vol_q, vol_d;
  logic [BriWidth-1:0]    bri_q, bri_d;
  logic [KeyValWidth-1:0] menu_held_q, menu_held_d;
  logic [KeyValWidth-1:0] up_held_q, up_held_d, up_fresh_q, up_fresh_d;
  logic [KeyValWidth-1:0] dn_held_q, dn_held_d, dn_fresh_q, dn_fresh_d;
  logic [TimeWidth-1:0]   up_due_q, up_due_d, dn_due_q, dn_due_d;
  logic [TimeWidth-1:0]   frame_time_q, frame_time_d, prev_time_q, prev_time_d;
  logic                   ignore_q, ignore_d;
  logic                   up_go, dn_go;
  logic [TimeWidth-1:0]   delay_ext, interval_ext, gap_ext;

  assign delay_ext    = {{(TimeWidth-CfgWidth){1'b0}}, cfg_i.repeat_delay_ms};
  assign interval_ext = {{(TimeWidth-CfgWidth){1'b0}}, cfg_i.repeat_interval_ms};
  assign gap_ext      = {{(TimeWidth-CfgWidth){1'b0}}, cfg_i.sleep_gap_ms};

  always_comb begin
    vol_d        = vol_q;
    bri_d        = bri_q;
    menu_held_d  = menu_held_q;
    up_held_d    = up_held_q;
    up_fresh_d   = up_fresh_q;
    up_due_d     = up_due_q;
    dn_held_d    = dn_held_q;
    dn_fresh_d   = dn_fresh_q;
    dn_due_d     = dn_due_q;
    frame_time_d = frame_time_q;
    prev_time_d  = prev_time_q;
    ignore_d     = ignore_q;
    up_go        = 1'b0;
    dn_go        = 1'b0;

    if (fire_i) begin
      case (item_i.command)
        CMD_FRAME_BEGIN: begin
          frame_time_d = item_i.time_ms;
          if ((item_i.time_ms - prev_time_q) > gap_ext) ignore_d = 1'b1;
        end
        CMD_KEY_EVENT: begin
          if (!ignore_q && item_i.event_is_key && (item_i.key_value != KEY_OTHER)) begin
            if (item_i.key_code == cfg_i.menu_key_code) begin
              menu_held_d = item_i.key_value;
            end else if (item_i.key_code == cfg_i.up_key_code) begin
              up_held_d  = item_i.key_value;
              up_fresh_d = item_i.key_value;
              if (item_i.key_value != KEY_RELEASED) up_due_d = frame_time_q + delay_ext;
            end else if (item_i.key_code == cfg_i.down_key_code) begin
              dn_held_d  = item_i.key_value;
              dn_fresh_d = item_i.key_value;
              if (item_i.key_value != KEY_RELEASED) dn_due_d = frame_time_q + delay_ext;
            end
          end
        end
        CMD_FRAME_END: begin
          // An ignored frame drops all key state, so nothing steps below.
          if (ignore_q) begin
            menu_held_d = '0;
            up_held_d   = '0;
            up_fresh_d  = '0;
            up_due_d    = '0;
            dn_held_d   = '0;
            dn_fresh_d  = '0;
            dn_due_d    = '0;
          end
          up_go = (up_fresh_d != '0) ||
                  ((up_held_d != '0) && (frame_time_q >= up_due_d));
          if (up_go) begin
            if (menu_held_d != '0) bri_d = step_brightness(bri_d, 1'b1);
            else vol_d = step_volume(vol_d, 1'b1);
            if (up_fresh_d != '0) up_fresh_d = '0;
            else up_due_d = up_due_d + interval_ext;
          end
          dn_go = (dn_fresh_d != '0) ||
                  ((dn_held_d != '0) && (frame_time_q >= dn_due_d));
          if (dn_go) begin
            if (menu_held_d != '0) bri_d = step_brightness(bri_d, 1'b0);
            else vol_d = step_volume(vol_d, 1'b0);
            if (dn_fresh_d != '0) dn_fresh_d = '0;
            else dn_due_d = dn_due_d + interval_ext;
          end
          prev_time_d = frame_time_q;
          ignore_d    = 1'b0;
        end
        default: ;
      endcase
    end

    if (load_i.vol_load) vol_d = load_i.vol_value;
    if (load_i.bri_load) bri_d = load_i.bri_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q        <= VolumeStartRst;
      bri_q        <= BrightnessStartRst;
      menu_held_q  <= '0;
      up_held_q    <= '0;
      up_fresh_q   <= '0;
      up_due_q     <= '0;
      dn_held_q    <= '0;
      dn_fresh_q   <= '0;
      dn_due_q     <= '0;
      frame_time_q <= '0;
      prev_time_q  <= '0;
      ignore_q     <= 1'b0;
    end else begin
      vol_q        <= vol_d;
      bri_q        <= bri_d;
      menu_held_q  <= menu_held_d;
      up_held_q    <= up_held_d;
      up_fresh_q   <= up_fresh_d;
      up_due_q     <= up_due_d;
      dn_held_q    <= dn_held_d;
      dn_fresh_q   <= dn_fresh_d;
      dn_due_q     <= dn_due_d;
      frame_time_q <= frame_time_d;
      prev_time_q  <= prev_time_d;
      ignore_q     <= ignore_d;
    end
  end

  assign result_o.volume        = vol_d;
  assign result_o.brightness    = bri_d;
  assign result_o.level_changed = (vol_d != vol_q) || (bri_d != bri_q);

endmodule

@@ design/hotkey_level_autorepeat.sv @@
// Hotkey level controller with typematic auto repeat for volume and brightness.
// Items arrive on the in_i channel: frame begin (carries the millisecond time),
// key event, and frame end. Every accepted item produces exactly one result on
// the out_o channel with the current volume, brightness and a flag that tells
// whether this item changed a level.
// The block has an input register and a result register. An accepted item is
// held in the input register; its result is computed from it and is written
// to the result register when out_o is not stalled, and is offered from there.
// One item can be accepted in every cycle while out_o is not stalled.
// The level state and the result are updated in one pass of logic between the
// two registers.
// When the receiver stalls, the result is held and the input register still
// takes one more item; after that in_i.ready drops until out_o is taken.
// Configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_wdata_i; the user must write only while no item is in flight, as the
// block does not enforce it. A start level loads at once, clamped to its top.
// Reset empties both registers, clears key state and times, and loads the
// default delays and start levels.
module hotkey_level_autorepeat (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hk_item_if.sink                        in_i,
  hk_result_if.source                    out_o,
  input  logic                           cfg_we_i,
  input  logic [hk_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [hk_pkg::CfgWidth-1:0]    cfg_wdata_i
);
  import hk_pkg::*;

  cfg_t        cfg;
  level_load_t load;
  item_t       item_q;
  logic        item_valid_q;
  result_t     result_q, result_d;
  logic        out_valid_q;
  logic        advance, fire;

  assign advance  = !out_valid_q || out_o.ready;
  assign fire     = item_valid_q && advance;
  assign in_i.ready = !item_valid_q || advance;

  hk_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .load_o      (load)
  );

  hk_level_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .load_i   (load),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_i.ready) item_valid_q <= in_i.valid;
      if (advance) out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.command      <= in_i.command;
      item_q.time_ms      <= in_i.time_ms;
      item_q.event_is_key <= in_i.event_is_key;
      item_q.key_code     <= in_i.key_code;
      item_q.key_value    <= in_i.key_value;
    end
    if (fire) result_q <= result_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.volume        = result_q.volume;
  assign out_o.brightness    = result_q.brightness;
  assign out_o.level_changed = result_q.level_changed;

endmodule
